/* rtl/mtt_pkg.sv */
`default_nettype none
package mtt_pkg;

   localparam int MaxTimersDefault = 16;
   localparam int MaxResults       = 16;

   typedef enum logic [2:0] {
      MODE_TICK    = 3'd0,
      MODE_START   = 3'd1,
      MODE_RESTART = 3'd2,
      MODE_STOP    = 3'd3,
      MODE_CYCLIC  = 3'd4,
      MODE_QUERY   = 3'd5
   } mode_type;

   typedef enum logic [2:0] {
      KIND_STARTED   = 3'd0,
      KIND_FULL      = 3'd1,
      KIND_RESTARTED = 3'd2,
      KIND_STOPPED   = 3'd3,
      KIND_NOT_FOUND = 3'd4,
      KIND_QUERY     = 3'd5,
      KIND_CYC_SET   = 3'd6,
      KIND_EXPIRED   = 3'd7
   } kind_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [15:0] job_id;
      logic [23:0] duration_ticks;
      logic        cyclic_flag;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [15:0] job_id_out;
      logic        running;
      logic        cyclic_out;
      logic        last;
   } rsp_type;

   // One entry as it travels along the ring of cells.
   typedef struct packed {
      logic        valid;
      logic [15:0] id;
      logic [23:0] duration;
      logic [23:0] remaining;
      logic        cyclic;
   } entry_type;

   // Command given to the head only, which alone acts on it; the cells just shift.
   typedef struct packed {
      logic        active;
      logic [2:0]  mode;
      logic [15:0] job_id;
      logic [23:0] duration;
      logic        cyclic;
      logic        write_start;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_APPLY = 2'd2,
      ST_EMIT = 2'd3
   } state_type;

endpackage
`default_nettype wire

/* rtl/mtt_cell.sv */
`default_nettype none
module mtt_cell
   import mtt_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      shift,
   input  wire entry_type entry_in,
   output entry_type      entry_out
);
   entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;
endmodule
`default_nettype wire

/* rtl/mtt_head.sv */
`default_nettype none
// Operates on the entry leaving the ring's head; the result re-enters at the tail.
module mtt_head
   import mtt_pkg::*;
(
   input  wire entry_type entry_in,
   input  wire cmd_type   cmd,
   input  wire logic      hit_here,
   input  wire logic      free_here,
   output entry_type      entry_out,
   output logic           expire_here
);
   always_comb begin
      entry_out   = entry_in;
      expire_here = 1'b0;
      if (cmd.active) begin
         unique case (cmd.mode)
            MODE_TICK: begin
               if (entry_in.valid) begin
                  if (entry_in.remaining > 24'd1) begin
                     entry_out.remaining = entry_in.remaining - 24'd1;
                  end else begin
                     expire_here = 1'b1;
                     if (entry_in.cyclic) begin
                        entry_out.remaining = entry_in.duration;
                     end else begin
                        entry_out.valid = 1'b0;
                     end
                  end
               end
            end
            MODE_START: begin
               if (hit_here || (cmd.write_start && free_here)) begin
                  entry_out.valid     = 1'b1;
                  entry_out.id        = cmd.job_id;
                  entry_out.duration  = cmd.duration;
                  entry_out.remaining = cmd.duration;
                  entry_out.cyclic    = cmd.cyclic;
               end
            end
            MODE_RESTART: if (hit_here) entry_out.remaining = entry_in.duration;
            MODE_STOP:    if (hit_here) entry_out.valid = 1'b0;
            MODE_CYCLIC:  if (hit_here) entry_out.cyclic = cmd.cyclic;
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

/* rtl/multi_timer_table.sv */
// Channel   | Ports                         | Handshake
// request   | start, busy, req_data         | taken when start && !busy
// response  | rsp_valid, rsp_data           | one cycle strobe, no backpressure
// A command passes from one transfer to the next through a search pass and
// an update pass, each rotating the ring of cells once, an emit state and an
// idle state. A tick skips the search pass and emits its expiry events one
// after another in the emit state. Reset is synchronous and clears the valid
// marks by a clearing rotation during which busy is high. Results cannot be
// stalled; a tick with many expiries emits them from a small event queue in
// slot order.
`default_nettype none
module multi_timer_table
   import mtt_pkg::*;
#(
   parameter int MAX_TIMERS = MaxTimersDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data
);
   localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CW = $clog2(MAX_TIMERS + 1);
   localparam int QW = $clog2(MaxResults + 1);
   localparam int QI = $clog2(MaxResults);

   state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic clear_ff, clear_in;
   req_type cmd_ff;
   logic hit_ff, free_ff;
   logic [IW-1:0] slot_ff;
   logic [15:0] qid_ff [MaxResults];
   logic qcyc_ff [MaxResults];
   logic [QW-1:0] qn_ff, qr_ff;

   entry_type ring [MAX_TIMERS];
   entry_type head_out;
   cmd_type   cmd;
   logic      expire_here, shift, hit_now, free_now, at_slot;
   logic      cnt_end;

   assign cnt_end = (cnt_ff == CW'(MAX_TIMERS - 1));
   assign shift   = (state_ff != ST_IDLE) && (state_ff != ST_EMIT);
   assign hit_now = ring[0].valid && (ring[0].id == cmd_ff.job_id);
   assign free_now = !ring[0].valid;
   assign at_slot = (cnt_ff[IW-1:0] == slot_ff);

   assign cmd.active      = (state_ff == ST_APPLY) && !clear_ff;
   assign cmd.mode        = cmd_ff.mode;
   assign cmd.job_id      = cmd_ff.job_id;
   assign cmd.duration    = cmd_ff.duration_ticks;
   assign cmd.cyclic      = cmd_ff.cyclic_flag;
   assign cmd.write_start = !hit_ff && free_ff;

   mtt_head u_head (
      .entry_in   (ring[0]),
      .cmd        (cmd),
      .hit_here   (hit_ff && at_slot),
      .free_here  (at_slot),
      .entry_out  (head_out),
      .expire_here(expire_here)
   );

   for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
      entry_type nin;
      if (g == MAX_TIMERS - 1) begin : g_tail
         always_comb begin
            nin = head_out;
            if (clear_ff) nin.valid = 1'b0;
         end
      end else begin : g_mid
         assign nin = ring[g+1];
      end
      mtt_cell u_cell (.clock(clock), .shift(shift), .entry_in(nin),
                       .entry_out(ring[g]));
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      clear_in = clear_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               state_in = (req_data.mode == MODE_TICK) ? ST_APPLY : ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_end ? '0 : cnt_ff + 1'b1;
            if (cnt_end) state_in = ST_APPLY;
         end
         ST_APPLY: begin
            cnt_in = cnt_end ? '0 : cnt_ff + 1'b1;
            if (cnt_end) begin
               clear_in = 1'b0;
               // The clearing rotation after reset has nothing to report.
               state_in = clear_ff ? ST_IDLE : ST_EMIT;
            end
         end
         ST_EMIT: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_EMIT && qr_ff + 1'b1 < qn_ff) state_in = ST_EMIT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_APPLY;
         cnt_ff   <= '0;
         clear_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         clear_ff <= clear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
         qn_ff   <= '0;
         qr_ff   <= '0;
      end else begin
         if (state_ff == ST_IDLE && start && !busy) begin
            cmd_ff  <= req_data;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            qn_ff   <= '0;
            qr_ff   <= '0;
         end
         if (state_ff == ST_SCAN) begin
            if (hit_now && !hit_ff) begin
               hit_ff  <= 1'b1;
               slot_ff <= cnt_ff[IW-1:0];
            end else if (free_now && !free_ff && !hit_ff && !hit_now) begin
               free_ff <= 1'b1;
               slot_ff <= cnt_ff[IW-1:0];
            end
         end
         if (cmd.active && expire_here && qn_ff < QW'(MaxResults)) begin
            qid_ff[qn_ff[QI-1:0]]  <= ring[0].id;
            qcyc_ff[qn_ff[QI-1:0]] <= ring[0].cyclic;
            qn_ff <= qn_ff + 1'b1;
         end
         if (state_ff == ST_EMIT) qr_ff <= qr_ff + 1'b1;
      end
   end

   // Output strobe and payload.
   always_comb begin
      rsp_valid = 1'b0;
      rsp_data  = '0;
      if (state_ff == ST_EMIT) begin
         rsp_data.job_id_out = cmd_ff.job_id;
         rsp_data.last       = 1'b1;
         unique case (cmd_ff.mode)
            MODE_TICK: begin
               rsp_valid = (qn_ff != '0);
               rsp_data.kind       = KIND_EXPIRED;
               rsp_data.job_id_out = qid_ff[qr_ff[QI-1:0]];
               rsp_data.cyclic_out = qcyc_ff[qr_ff[QI-1:0]];
               rsp_data.last       = (qr_ff + 1'b1 == qn_ff);
            end
            MODE_START: begin
               rsp_valid = 1'b1;
               rsp_data.kind = (hit_ff || free_ff) ? KIND_STARTED : KIND_FULL;
            end
            MODE_RESTART: begin
               rsp_valid = 1'b1;
               rsp_data.kind = hit_ff ? KIND_RESTARTED : KIND_NOT_FOUND;
            end
            MODE_STOP: begin
               rsp_valid = 1'b1;
               rsp_data.kind = hit_ff ? KIND_STOPPED : KIND_NOT_FOUND;
            end
            MODE_CYCLIC: begin
               rsp_valid = 1'b1;
               rsp_data.kind = hit_ff ? KIND_CYC_SET : KIND_NOT_FOUND;
            end
            MODE_QUERY: begin
               rsp_valid = 1'b1;
               rsp_data.kind    = KIND_QUERY;
               rsp_data.running = hit_ff;
            end
            default: ;
         endcase
      end
   end

   assign busy = (state_ff != ST_IDLE);

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("response outside an operation");
   a_cnt_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cnt_ff == '0)) else $error("emit with ring misaligned");
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      qn_ff <= QW'(MaxResults)) else $error("event queue overflow");
endmodule
`default_nettype wire

/* test/multi_timer_table_tb.sv */
`default_nettype none
module multi_timer_table_tb;
   import mtt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSlots = MaxTimersDefault;
   localparam int CycleLimit = 400000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   multi_timer_table dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // Predicted copy of the timer table.
   logic        tbl_valid [NumSlots];
   logic [15:0] tbl_id [NumSlots];
   logic [23:0] tbl_dur [NumSlots];
   logic [23:0] tbl_rem [NumSlots];
   logic        tbl_cyc [NumSlots];

   req_type pending_reqs[$];
   rsp_type expected_events[$];
   int      errors = 0;
   int      cycles = 0;
   int      idle_left = 0;
   bit      allow_idle = 1'b1;
   int      events_seen = 0;
   int      expiries_seen = 0;

   function automatic rsp_type make_rsp(logic [2:0] kind, logic [15:0] id,
                                        logic run, logic cyc, logic lst);
      rsp_type r;
      r.kind = kind;
      r.job_id_out = id;
      r.running = run;
      r.cyclic_out = cyc;
      r.last = lst;
      return r;
   endfunction

   function automatic int find_timer(logic [15:0] id);
      for (int i = 0; i < NumSlots; i++)
         if (tbl_valid[i] && tbl_id[i] == id) return i;
      return -1;
   endfunction

   task automatic predict_timer_op(req_type rq);
      int s;
      int n;
      n = 0;
      s = find_timer(rq.job_id);
      case (rq.mode)
         MODE_TICK: begin
            for (int i = 0; i < NumSlots; i++) begin
               if (!tbl_valid[i]) continue;
               if (tbl_rem[i] > 24'd1) begin
                  tbl_rem[i] = tbl_rem[i] - 24'd1;
                  continue;
               end
               if (n < MaxResults) begin
                  expected_events.push_back(make_rsp(KIND_EXPIRED, tbl_id[i], 1'b0,
                                                     tbl_cyc[i], 1'b0));
                  n++;
               end
               if (tbl_cyc[i]) tbl_rem[i] = tbl_dur[i];
               else tbl_valid[i] = 1'b0;
            end
            if (n > 0) expected_events[$].last = 1'b1;
         end
         MODE_START: begin
            if (s < 0)
               for (int i = 0; i < NumSlots; i++)
                  if (!tbl_valid[i]) begin
                     s = i;
                     break;
                  end
            if (s < 0) begin
               expected_events.push_back(make_rsp(KIND_FULL, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end else begin
               tbl_valid[s] = 1'b1;
               tbl_id[s] = rq.job_id;
               tbl_dur[s] = rq.duration_ticks;
               tbl_rem[s] = rq.duration_ticks;
               tbl_cyc[s] = rq.cyclic_flag;
               expected_events.push_back(make_rsp(KIND_STARTED, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end
         end
         MODE_RESTART, MODE_STOP, MODE_CYCLIC: begin
            if (s < 0) begin
               expected_events.push_back(make_rsp(KIND_NOT_FOUND, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end else if (rq.mode == MODE_RESTART) begin
               tbl_rem[s] = tbl_dur[s];
               expected_events.push_back(make_rsp(KIND_RESTARTED, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end else if (rq.mode == MODE_STOP) begin
               tbl_valid[s] = 1'b0;
               expected_events.push_back(make_rsp(KIND_STOPPED, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end else begin
               tbl_cyc[s] = rq.cyclic_flag;
               expected_events.push_back(make_rsp(KIND_CYC_SET, rq.job_id,
                                                  1'b0, 1'b0, 1'b1));
            end
         end
         MODE_QUERY: begin
            expected_events.push_back(make_rsp(KIND_QUERY, rq.job_id, s >= 0,
                                               1'b0, 1'b1));
         end
         default: begin
         end
      endcase
   endtask

   function automatic req_type make_req(logic [2:0] mode, logic [15:0] id,
                                        logic [23:0] dur, logic cyc);
      req_type r;
      r.mode = mode;
      r.job_id = id;
      r.duration_ticks = dur;
      r.cyclic_flag = cyc;
      return r;
   endfunction

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Driver: a transfer completes at an edge where start is high and busy low.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_timer_op(req_data);
            void'(pending_reqs.pop_front());
         end
         if (start && busy) begin
            // Hold the item until it is taken.
         end else if (idle_left > 0) begin
            idle_left--;
            start <= 1'b0;
         end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            idle_left = $urandom_range(1, 15);
            start <= 1'b0;
         end else if (pending_reqs.size() > 0 && !(start && !busy &&
                                                  pending_reqs.size() == 0)) begin
            start <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      cycles++;
      if (!reset && rsp_valid) begin
         events_seen++;
         if (rsp_data.kind == KIND_EXPIRED) expiries_seen++;
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_events.pop_front();
            if (e.kind != rsp_data.kind || e.job_id_out != rsp_data.job_id_out ||
                e.running != rsp_data.running || e.cyclic_out != rsp_data.cyclic_out ||
                e.last != rsp_data.last) begin
               $display("%0t: mismatch expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
      if (cycles > CycleLimit) begin
         $display("%0t: timeout", $time);
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      logic [15:0] ids [8];
      int          k;
      logic [2:0]  md;
      for (int i = 0; i < NumSlots; i++) tbl_valid[i] = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, every mode, unknown ids, full table, zero duration.
      pending_reqs.push_back(make_req(MODE_QUERY, 16'hFFFF, 24'hFFFFFF, 1'b1));
      pending_reqs.push_back(make_req(MODE_RESTART, 16'h0000, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(MODE_STOP, 16'h1234, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(MODE_CYCLIC, 16'h1234, 24'd0, 1'b1));
      pending_reqs.push_back(make_req(MODE_TICK, 16'd0, 24'd0, 1'b0));
      for (int i = 0; i < NumSlots; i++)
         pending_reqs.push_back(make_req(MODE_START, 16'(i * 4099), 24'(i % 3),
                                         i[0]));
      pending_reqs.push_back(make_req(MODE_START, 16'hFFFF, 24'hFFFFFF, 1'b1));
      pending_reqs.push_back(make_req(MODE_START, 16'd4099, 24'hFFFFFF, 1'b0));
      pending_reqs.push_back(make_req(MODE_TICK, 16'hFFFF, 24'hFFFFFF, 1'b1));
      pending_reqs.push_back(make_req(3'd6, 16'd0, 24'd0, 1'b0));
      pending_reqs.push_back(make_req(3'd7, 16'hFFFF, 24'hFFFFFF, 1'b1));

      // Random: ids drawn mostly from a small pool so that commands hit.
      for (int i = 0; i < 8; i++) ids[i] = 16'($urandom);
      for (int i = 0; i < 480; i++) begin
         k = $urandom_range(0, 99);
         if (k < 35) md = MODE_TICK;
         else if (k < 60) md = MODE_START;
         else if (k < 95) md = 3'($urandom_range(2, 5));
         else md = 3'($urandom_range(6, 7));
         pending_reqs.push_back(make_req(md,
            ($urandom_range(0, 9) == 0) ? 16'($urandom) : ids[$urandom_range(0, 7)],
            ($urandom_range(0, 19) == 0) ? 24'($urandom) : 24'($urandom_range(0, 6)),
            1'($urandom)));
         if (i == 400) begin
            while (pending_reqs.size() > 60) @(posedge clock);
            allow_idle = 1'b0;
         end
      end

      while (pending_reqs.size() > 0 || start || expected_events.size() > 0)
         @(posedge clock);
      repeat (4 * NumSlots + 40) @(posedge clock);
      $display("Covered all modes, full table, zero durations and %0d results",
               events_seen);
      $display("of which %0d were expiries.", expiries_seen);
      if (errors == 0 && expected_events.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule
`default_nettype wire
